>>> src/tpps_pkg.sv
// Shared constants for the two-pointer pair-sum search block.
// No dependencies; imported by the search controller and the top level.
package tpps_pkg;

    // Most pairs reported by one search
    localparam int MAX_RESULTS = 32;
    // Width of the reported-pair counter, holds MAX_RESULTS itself
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

endpackage

>>> src/tpps_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module tpps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> src/tpps_ctrl.sv
// Load and search controller: appends elements to the store, walks the two
// pointers over it and drives the result register. Uses tpps_pkg.
module tpps_ctrl
    import tpps_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // element request
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [DATA_WIDTH-1:0]    in_value,
    input  logic                     in_last,
    // configured target
    input  logic [DATA_WIDTH-1:0]    target,
    // element store
    output logic                     ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
    output logic [DATA_WIDTH-1:0]    ram_wr_data,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr_lo,
    input  logic [DATA_WIDTH-1:0]    ram_rd_data_lo,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr_hi,
    input  logic [DATA_WIDTH-1:0]    ram_rd_data_hi,
    // result request
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_pair,
    output logic [DATA_WIDTH-1:0]    out_lo,
    output logic [DATA_WIDTH-1:0]    out_hi,
    output logic                     out_last,
    output logic                     out_ovf
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = AW + 1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_WAIT,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  ovf_reg;
    logic [AW-1:0]         low_reg;
    logic [AW-1:0]         high_reg;
    logic [RES_CNT_W-1:0]  n_reg;
    logic                  have_prev_reg;
    logic [DATA_WIDTH-1:0] prev_lo_reg;
    logic [DATA_WIDTH-1:0] prev_hi_reg;
    logic                  pend_valid_reg;
    logic [DATA_WIDTH-1:0] pend_lo_reg;
    logic [DATA_WIDTH-1:0] pend_hi_reg;
    logic                  out_valid_reg;
    logic                  out_pair_reg;
    logic [DATA_WIDTH-1:0] out_lo_reg;
    logic [DATA_WIDTH-1:0] out_hi_reg;
    logic                  out_last_reg;
    logic                  out_ovf_reg;

    logic                  accept;
    logic                  full;
    logic                  out_free;
    logic                  out_load;
    logic signed [DATA_WIDTH:0] sum;
    logic signed [DATA_WIDTH:0] target_ext;
    logic                  ordered;
    logic                  hit;
    logic                  below;
    logic                  dup;

    assign in_ready  = (state_reg == S_LOAD);
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign out_free  = !out_valid_reg || out_ready;

    assign ram_wr_en      = accept && !full;
    assign ram_wr_addr    = count_reg[AW-1:0];
    assign ram_wr_data    = in_value;
    assign ram_rd_addr_lo = low_reg;
    assign ram_rd_addr_hi = high_reg;

    // Exact sum, one guard bit so it cannot wrap
    assign sum        = $signed({ram_rd_data_lo[DATA_WIDTH-1], ram_rd_data_lo})
                      + $signed({ram_rd_data_hi[DATA_WIDTH-1], ram_rd_data_hi});
    assign target_ext = $signed({target[DATA_WIDTH-1], target});
    assign ordered    = $signed(ram_rd_data_lo) < $signed(ram_rd_data_hi);
    assign hit        = (sum == target_ext);
    assign below      = (sum < target_ext);
    assign dup        = have_prev_reg && (prev_lo_reg == ram_rd_data_lo)
                      && (prev_hi_reg == ram_rd_data_hi);

    // Load the result register: a pending pair pushed out, or the final result
    assign out_load   = ((state_reg == S_EVAL) && ordered && hit && !dup
                         && pend_valid_reg && out_free)
                      || ((state_reg == S_FINISH) && out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            low_reg        <= '0;
            high_reg       <= '0;
            n_reg          <= '0;
            have_prev_reg  <= 1'b0;
            prev_lo_reg    <= '0;
            prev_hi_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_lo_reg    <= '0;
            pend_hi_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_pair_reg   <= 1'b0;
            out_lo_reg     <= '0;
            out_hi_reg     <= '0;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        ovf_reg <= ovf_reg | full;
                        if (in_last)
                        begin
                            low_reg        <= '0;
                            high_reg       <= full ? AW'(DEPTH - 1) : count_reg[AW-1:0];
                            n_reg          <= '0;
                            have_prev_reg  <= 1'b0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= S_WAIT;
                        end
                    end
                end

                // store read of the current pointers is in flight
                S_WAIT:
                begin
                    if ((low_reg < high_reg) && (n_reg != RES_CNT_W'(MAX_RESULTS)))
                    begin
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_EVAL:
                begin
                    if (!ordered)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (hit)
                    begin
                        if (dup)
                        begin
                            low_reg   <= low_reg + 1'b1;
                            high_reg  <= high_reg - 1'b1;
                            state_reg <= S_WAIT;
                        end
                        // hold until the older pending pair can leave
                        else if (!pend_valid_reg || out_free)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_pair_reg  <= 1'b1;
                                out_lo_reg    <= pend_lo_reg;
                                out_hi_reg    <= pend_hi_reg;
                                out_last_reg  <= 1'b0;
                                out_ovf_reg   <= ovf_reg;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_lo_reg    <= ram_rd_data_lo;
                            pend_hi_reg    <= ram_rd_data_hi;
                            prev_lo_reg    <= ram_rd_data_lo;
                            prev_hi_reg    <= ram_rd_data_hi;
                            have_prev_reg  <= 1'b1;
                            n_reg          <= n_reg + 1'b1;
                            low_reg        <= low_reg + 1'b1;
                            high_reg       <= high_reg - 1'b1;
                            state_reg      <= S_WAIT;
                        end
                    end
                    else if (below)
                    begin
                        low_reg   <= low_reg + 1'b1;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        high_reg  <= high_reg - 1'b1;
                        state_reg <= S_WAIT;
                    end
                end

                // send the final pair, or the empty marker, then clear the list
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_pair_reg   <= pend_valid_reg;
                        out_lo_reg     <= pend_valid_reg ? pend_lo_reg : '0;
                        out_hi_reg     <= pend_valid_reg ? pend_hi_reg : '0;
                        out_last_reg   <= 1'b1;
                        out_ovf_reg    <= ovf_reg;
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                        low_reg        <= '0;
                        high_reg       <= '0;
                        have_prev_reg  <= 1'b0;
                        prev_lo_reg    <= '0;
                        prev_hi_reg    <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pair  = out_pair_reg;
    assign out_lo    = out_lo_reg;
    assign out_hi    = out_hi_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

>>> src/two_pointer_pair_sum_search.sv
// Top level of the two-pointer pair-sum search: target register, element
// store and search controller. Uses tpps_pkg, tpps_ram and tpps_ctrl.
//
//  Channel   Dir  Fields (tdata / tuser / tlast)
//  s_axis    in   tdata: value | tlast: last_element
//  m_axis    out  tdata: low_value, high_value, overflowed | tuser: pair_valid
//                 | tlast: last_result
//  target    in   target_sum_wr_en + target_sum_wr_data, written when enable high
//
// Elements load at one per cycle while no search runs. The request marked last
// starts a search in which each pointer step is a store read, then a compare;
// input is held off until the final result has been loaded into the output
// register, which waits on any output stall.
// Reset clears the element count, flags and target; store contents are
// not cleared. A stalled result holds the search when a new pair must
// push the pending one out, and holds the final result until the output frees.
module two_pointer_pair_sum_search
    import tpps_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  target_sum_wr_en,
    input  logic [DATA_WIDTH-1:0] target_sum_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // value
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // low_value, high_value, overflowed
    output logic [((2*DATA_WIDTH+8)/8)*8-1:0] m_axis_tdata,
    // pair_valid
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int AW      = $clog2(DEPTH);
    localparam int OUT_W   = ((2*DATA_WIDTH+8)/8)*8;
    localparam int OUT_PAD = OUT_W - 2*DATA_WIDTH - 1;

    logic [DATA_WIDTH-1:0] target_reg;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic [AW-1:0]         ram_rd_addr_lo;
    logic [DATA_WIDTH-1:0] ram_rd_data_lo;
    logic [AW-1:0]         ram_rd_addr_hi;
    logic [DATA_WIDTH-1:0] ram_rd_data_hi;
    logic [DATA_WIDTH-1:0] res_lo;
    logic [DATA_WIDTH-1:0] res_hi;
    logic                  res_ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (target_sum_wr_en)
        begin
            target_reg <= target_sum_wr_data;
        end
    end

    tpps_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_addr_lo),
        .rd_data_a (ram_rd_data_lo),
        .rd_addr_b (ram_rd_addr_hi),
        .rd_data_b (ram_rd_data_hi)
    );

    tpps_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_value       (s_axis_tdata[DATA_WIDTH-1:0]),
        .in_last        (s_axis_tlast),
        .target         (target_reg),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_addr_lo (ram_rd_addr_lo),
        .ram_rd_data_lo (ram_rd_data_lo),
        .ram_rd_addr_hi (ram_rd_addr_hi),
        .ram_rd_data_hi (ram_rd_data_hi),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_pair       (m_axis_tuser),
        .out_lo         (res_lo),
        .out_hi         (res_hi),
        .out_last       (m_axis_tlast),
        .out_ovf        (res_ovf)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, res_ovf, res_hi, res_lo};

endmodule
